### rtl/mplf_pkg.sv
`timescale 1ns / 1ps

package mplf_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_MATCH_MODE      = 3'd0;
    localparam logic [2:0] CFG_PATTERN_COUNT   = 3'd1;
    localparam logic [2:0] CFG_PATTERN_LENGTHS = 3'd2;
    localparam logic [2:0] CFG_PATTERN_ZERO    = 3'd3;
    localparam logic [2:0] CFG_PATTERN_THREE   = 3'd6;

    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int PATTERN_SLOTS = 4;
    localparam int LEN_FIELD_W   = 4;
    localparam int LINE_NUM_W    = 32;
    localparam int MASK_W        = 4;
    localparam int OUT_TDATA_W   = 40;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] NUL_BYTE     = 8'd0;

    // control registers shared by the matcher and the line logic
    typedef struct packed {
        logic        match_mode;
        logic [2:0]  pattern_count;
        logic [15:0] pattern_lengths;
    } cfg_ctrl_t;

endpackage

### rtl/mplf_cfg_regs.sv
`timescale 1ns / 1ps

module mplf_cfg_regs #(
    parameter int NUM_PATTERNS    = 4,
    parameter int MAX_PATTERN_LEN = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mplf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mplf_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mplf_pkg::cfg_ctrl_t                  ctrl,
    output logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN*8-1:0] patterns
);
    import mplf_pkg::*;

    localparam int PAT_W = MAX_PATTERN_LEN * 8;

    cfg_ctrl_t                          ctrl_reg;
    logic [NUM_PATTERNS-1:0][PAT_W-1:0] pattern_reg;
    logic                               wr_en;
    logic                               pat_sel;
    logic [1:0]                         pat_slot;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid;
    assign pat_sel   = (cfg_index >= CFG_PATTERN_ZERO) && (cfg_index <= CFG_PATTERN_THREE);
    assign pat_slot  = 2'(cfg_index - CFG_PATTERN_ZERO);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.match_mode      <= 1'b0;
            ctrl_reg.pattern_count   <= 3'd1;
            ctrl_reg.pattern_lengths <= 16'd4369;
        end
        else if (wr_en)
        begin
            unique case (cfg_index)
                CFG_MATCH_MODE:      ctrl_reg.match_mode      <= cfg_data[0];
                CFG_PATTERN_COUNT:   ctrl_reg.pattern_count   <= cfg_data[2:0];
                CFG_PATTERN_LENGTHS: ctrl_reg.pattern_lengths <= cfg_data[15:0];
                default:             ctrl_reg <= ctrl_reg;
            endcase
        end
    end

    // pattern bytes, only the slots and bytes that can be used are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
        end
        else if (wr_en && pat_sel)
        begin
            for (int k = 0; k < NUM_PATTERNS; k++)
            begin
                if (pat_slot == 2'(k))
                begin
                    pattern_reg[k] <= cfg_data[PAT_W-1:0];
                end
            end
        end
    end

    assign ctrl     = ctrl_reg;
    assign patterns = pattern_reg;

endmodule

### rtl/mplf_matcher.sv
`timescale 1ns / 1ps

module mplf_matcher #(
    parameter int NUM_PATTERNS    = 4,
    parameter int MAX_PATTERN_LEN = 8,
    parameter int HIST_DEPTH      = 7,
    parameter int FILL_W          = 4
) (
    input  mplf_pkg::cfg_ctrl_t                            ctrl,
    input  logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN*8-1:0] patterns,
    input  logic [HIST_DEPTH-1:0][7:0]                     history,
    input  logic [FILL_W-1:0]                              fill,
    input  logic                                           cut_by_nul,
    input  logic [7:0]                                     cur_byte,
    output logic [NUM_PATTERNS-1:0]                        hits
);
    import mplf_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
    localparam int IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

    logic [MAX_PATTERN_LEN-1:0][7:0] window;

    // window byte d back from the newest, d = 0 is the current byte
    always_comb
    begin
        window[0] = cur_byte;
        for (int d = 1; d < MAX_PATTERN_LEN; d++)
        begin
            window[d] = history[d-1];
        end
    end

    // every pattern compared against the window ending at the current byte
    always_comb
    begin
        logic [LEN_FIELD_W-1:0] len_field;
        logic [LEN_W-1:0]       len;
        logic [IDX_W-1:0]       d_idx;
        logic                   bytes_ok;
        logic                   room_ok;
        len_field = '0;
        len       = '0;
        d_idx     = '0;
        bytes_ok  = 1'b0;
        room_ok   = 1'b0;
        for (int k = 0; k < NUM_PATTERNS; k++)
        begin
            len_field = ctrl.pattern_lengths[LEN_FIELD_W*k +: LEN_FIELD_W];
            len = (len_field > LEN_FIELD_W'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN)
                                                             : LEN_W'(len_field);
            bytes_ok = 1'b1;
            for (int j = 0; j < MAX_PATTERN_LEN; j++)
            begin
                if (LEN_W'(j) < len)
                begin
                    d_idx = IDX_W'(int'(len) - 1 - j);
                    if (window[d_idx] != patterns[k][8*j +: 8])
                    begin
                        bytes_ok = 1'b0;
                    end
                end
            end
            room_ok = (5'(len) <= (5'(fill) + 5'd1));
            hits[k] = (len == '0) ||
                      (!cut_by_nul && (cur_byte != NUL_BYTE) && room_ok && bytes_ok);
        end
    end

endmodule

### rtl/multi_pattern_line_filter.sv
`timescale 1ns / 1ps

// Line filter over a byte stream: each word on s_ is one text byte, and for every line
// (ended by a newline byte or by the word with tlast set) one word leaves on m_ with the
// line number, the mask of patterns found in the line and the any/all selected flag.
// One byte is taken every cycle unless a blocked result stalls it; a line's last byte goes
// via the input register and the parallel window compare into the result register. The user must
// write patterns and mode through cfg_ only while the stream is idle; it is not enforced.
module multi_pattern_line_filter #(
    parameter int NUM_PATTERNS    = 4,
    parameter int MAX_PATTERN_LEN = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // text_byte
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,
    input  logic                                   s_tlast,
    // line_number [31:0], found_mask [35:32], zero pad [39:36]
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [mplf_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // selected
    output logic                                   m_tuser,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mplf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [mplf_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import mplf_pkg::*;

    localparam int HIST_DEPTH = (MAX_PATTERN_LEN > 1) ? MAX_PATTERN_LEN - 1 : 1;
    localparam int FILL_W     = $clog2(MAX_PATTERN_LEN + 1);

    cfg_ctrl_t                                    ctrl;
    logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN*8-1:0] patterns;

    logic                             in_valid_reg;
    logic [7:0]                       in_byte_reg;
    logic                             in_last_reg;

    logic [HIST_DEPTH-1:0][7:0]       hist_reg;
    logic [HIST_DEPTH-1:0][7:0]       hist_next;
    logic [FILL_W-1:0]                fill_reg;
    logic [FILL_W-1:0]                fill_next;
    logic [NUM_PATTERNS-1:0]          found_reg;
    logic [NUM_PATTERNS-1:0]          found_next;
    logic                             cut_reg;
    logic                             cut_next;
    logic [LINE_NUM_W-1:0]            line_cnt_reg;
    logic [LINE_NUM_W-1:0]            line_cnt_next;
    logic [LINE_NUM_W-1:0]            line_num_inc;

    logic                             out_valid_reg;
    logic [LINE_NUM_W-1:0]            out_line_reg;
    logic [MASK_W-1:0]                out_mask_reg;
    logic                             out_sel_reg;
    logic [MASK_W-1:0]                mask_now;
    logic                             sel_now;

    logic [NUM_PATTERNS-1:0]          hits;
    logic [MASK_W-1:0]                active;
    logic [2:0]                       n_active;
    logic                             advance;
    logic                             line_end;

    mplf_cfg_regs #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .patterns  (patterns)
    );

    mplf_matcher #(
        .NUM_PATTERNS    (NUM_PATTERNS),
        .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
        .HIST_DEPTH      (HIST_DEPTH),
        .FILL_W          (FILL_W)
    ) u_match (
        .ctrl       (ctrl),
        .patterns   (patterns),
        .history    (hist_reg),
        .fill       (fill_reg),
        .cut_by_nul (cut_reg),
        .cur_byte   (in_byte_reg),
        .hits       (hits)
    );

    // handshake: the held byte moves on when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign line_end = (in_byte_reg == NEWLINE_BYTE) || in_last_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // active pattern set, count zero means one
    always_comb
    begin
        if (ctrl.pattern_count == 3'd0)
        begin
            n_active = 3'd1;
        end
        else if (ctrl.pattern_count > 3'(NUM_PATTERNS))
        begin
            n_active = 3'(NUM_PATTERNS);
        end
        else
        begin
            n_active = ctrl.pattern_count;
        end
        for (int k = 0; k < MASK_W; k++)
        begin
            active[k] = (3'(k) < n_active);
        end
    end

    // line state update and result
    always_comb
    begin
        logic [NUM_PATTERNS-1:0] found_all;
        found_all     = found_reg | (hits & active[NUM_PATTERNS-1:0]);
        mask_now      = MASK_W'(found_all) & active;
        sel_now       = ctrl.match_mode ? (mask_now == active) : (mask_now != '0);
        line_num_inc  = (line_cnt_reg == '1) ? line_cnt_reg : line_cnt_reg + 1'b1;
        hist_next     = hist_reg;
        fill_next     = fill_reg;
        found_next    = found_all;
        cut_next      = cut_reg || (in_byte_reg == NUL_BYTE);
        line_cnt_next = line_cnt_reg;
        if (line_end)
        begin
            hist_next     = '0;
            fill_next     = '0;
            found_next    = '0;
            cut_next      = 1'b0;
            line_cnt_next = in_last_reg ? '0 : line_num_inc;
        end
        else
        begin
            for (int i = HIST_DEPTH - 1; i > 0; i--)
            begin
                hist_next[i] = hist_reg[i-1];
            end
            hist_next[0] = in_byte_reg;
            if (fill_reg < FILL_W'(MAX_PATTERN_LEN - 1))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg     <= '0;
            fill_reg     <= '0;
            found_reg    <= '0;
            cut_reg      <= 1'b0;
            line_cnt_reg <= '0;
        end
        else if (advance)
        begin
            hist_reg     <= hist_next;
            fill_reg     <= fill_next;
            found_reg    <= found_next;
            cut_reg      <= cut_next;
            line_cnt_reg <= line_cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && line_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && line_end)
        begin
            out_line_reg <= line_num_inc;
            out_mask_reg <= mask_now;
            out_sel_reg  <= sel_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - LINE_NUM_W - MASK_W){1'b0}}, out_mask_reg, out_line_reg};
    assign m_tuser  = out_sel_reg;

    // checks
    a_mask_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_mask_reg & ~active) == '0))
        else $error("found mask outside the active patterns");

    a_sel_rule: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_sel_reg == (ctrl.match_mode ? (out_mask_reg == active)
                                                      : (out_mask_reg != '0))))
        else $error("selected flag disagrees with mask and mode");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_line_reg != '0))
        else $error("line number of zero on output");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

endmodule
